>>> design/csg_pkg.sv
// shared codes for the closest-point-on-segment pipeline
// no dependencies
package csg_pkg;

   typedef enum logic [1:0] {
      CLAMP_INTERIOR   = 2'd0,
      CLAMP_START      = 2'd1,
      CLAMP_END        = 2'd2,
      CLAMP_DEGENERATE = 2'd3
   } clamp_type;

endpackage

>>> design/closest_point_on_segment_unit.sv
// closest point on a 2-d segment, fully pipelined top level
// depends on csg_pkg (clamp codes)
//
// One query enters per clock and is never held off: busy stays low and a
// transfer happens on every cycle that start is high. The result appears
// on the rsp_ ports for one cycle with rsp_valid high; the receiver must
// take it then. The pipeline is made up of the projection divider (one
// quotient bit per stage, FRAC_BITS + 1 stages) and the square root (one
// root bit per stage, COORD_WIDTH + 1 stages), plus the product, sum and
// point stages around them. The projection parameter is rounded down, the
// interior point offset truncates toward zero, and the distance is the
// floor of the exact root, clipped to all ones with rsp_distance_saturated
// set when it does not fit.
module closest_point_on_segment_unit #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_query_x,
   input  logic signed [COORD_WIDTH-1:0] req_query_y,
   output logic                          rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_nearest_x,
   output logic signed [COORD_WIDTH-1:0] rsp_nearest_y,
   output logic [1:0]                    rsp_clamp_case,
   output logic [COORD_WIDTH-1:0]        rsp_distance,
   output logic                          rsp_distance_saturated
);

   localparam int W  = COORD_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int DW = W + 1;       // coordinate difference
   localparam int PW = 2 * W + 2;   // product of two differences
   localparam int SW = 2 * W + 3;   // signed dot product
   localparam int QW = F + 1;       // projection parameter, 0 .. 2^F
   localparam int OW = DW + QW;     // offset product

   // geometry carried along the divider
   typedef struct packed {
      logic signed [W-1:0]  ax;
      logic signed [W-1:0]  ay;
      logic signed [W-1:0]  bx;
      logic signed [W-1:0]  by;
      logic signed [W-1:0]  px;
      logic signed [W-1:0]  py;
      logic signed [DW-1:0] abx;
      logic signed [DW-1:0] aby;
      csg_pkg::clamp_type   kind;
   } geo_type;

   // point carried along the square root
   typedef struct packed {
      logic signed [W-1:0] nx;
      logic signed [W-1:0] ny;
      csg_pkg::clamp_type  kind;
   } pnt_type;

   // never stalls
   assign busy = 1'b0;

   // ---------------------------------------------------------------
   // stage 1: differences
   // ---------------------------------------------------------------
   logic                 s1_valid_ff;
   geo_type              s1_geo_ff;
   logic signed [DW-1:0] s1_apx_ff, s1_apy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
      s1_geo_ff.ax   <= req_seg_a_x;
      s1_geo_ff.ay   <= req_seg_a_y;
      s1_geo_ff.bx   <= req_seg_b_x;
      s1_geo_ff.by   <= req_seg_b_y;
      s1_geo_ff.px   <= req_query_x;
      s1_geo_ff.py   <= req_query_y;
      s1_geo_ff.abx  <= DW'(req_seg_b_x) - DW'(req_seg_a_x);
      s1_geo_ff.aby  <= DW'(req_seg_b_y) - DW'(req_seg_a_y);
      s1_geo_ff.kind <= csg_pkg::CLAMP_INTERIOR;
      s1_apx_ff      <= DW'(req_query_x) - DW'(req_seg_a_x);
      s1_apy_ff      <= DW'(req_query_y) - DW'(req_seg_a_y);
   end

   // ---------------------------------------------------------------
   // stage 2: four products
   // ---------------------------------------------------------------
   logic                 s2_valid_ff;
   geo_type              s2_geo_ff;
   logic signed [PW-1:0] s2_dx_ff, s2_dy_ff, s2_lx_ff, s2_ly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_geo_ff <= s1_geo_ff;
      s2_dx_ff  <= s1_geo_ff.abx * s1_apx_ff;
      s2_dy_ff  <= s1_geo_ff.aby * s1_apy_ff;
      s2_lx_ff  <= s1_geo_ff.abx * s1_geo_ff.abx;
      s2_ly_ff  <= s1_geo_ff.aby * s1_geo_ff.aby;
   end

   // ---------------------------------------------------------------
   // stage 3: dot product, squared length and clamp decision
   // ---------------------------------------------------------------
   logic signed [SW-1:0] dot_in;
   logic [PW-1:0]        len2_in;
   geo_type              s3_geo_in;

   always_comb begin
      dot_in    = SW'(s2_dx_ff) + SW'(s2_dy_ff);
      len2_in   = PW'($unsigned(s2_lx_ff)) + PW'($unsigned(s2_ly_ff));
      s3_geo_in = s2_geo_ff;
      if (len2_in == '0) begin
         s3_geo_in.kind = csg_pkg::CLAMP_DEGENERATE;
      end else if (dot_in[SW-1]) begin
         s3_geo_in.kind = csg_pkg::CLAMP_START;
      end else if ($unsigned(dot_in) > SW'(len2_in)) begin
         s3_geo_in.kind = csg_pkg::CLAMP_END;
      end else begin
         s3_geo_in.kind = csg_pkg::CLAMP_INTERIOR;
      end
   end

   // divider pipeline, entry 0 is loaded here, entry k+1 is the output of bit stage k
   logic          div_valid_ff [0:F+1];
   geo_type       div_geo_ff   [0:F+1];
   logic [PW-1:0] div_rem_ff   [0:F+1];
   logic [PW-1:0] div_len2_ff  [0:F+1];
   logic [QW-1:0] div_q_ff     [0:F+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else begin
         div_valid_ff[0] <= s2_valid_ff;
      end
      div_geo_ff[0]  <= s3_geo_in;
      div_len2_ff[0] <= len2_in;
      div_q_ff[0]    <= '0;
      // only the interior case uses the quotient; keep the remainder in range otherwise
      if (s3_geo_in.kind == csg_pkg::CLAMP_INTERIOR) begin
         div_rem_ff[0] <= PW'($unsigned(dot_in));
      end else begin
         div_rem_ff[0] <= '0;
      end
   end

   // ---------------------------------------------------------------
   // divider: one quotient bit per stage, msb first
   // ---------------------------------------------------------------
   for (genvar k = 0; k <= F; k++) begin : g_div
      logic [PW:0]   trial;
      logic          take;
      logic [PW-1:0] rem_in;

      always_comb begin
         if (k == 0) begin
            trial = {1'b0, div_rem_ff[k]};
         end else begin
            trial = {div_rem_ff[k], 1'b0};
         end
         take   = trial >= {1'b0, div_len2_ff[k]};
         rem_in = take ? PW'(trial - {1'b0, div_len2_ff[k]}) : PW'(trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[k+1] <= 1'b0;
         end else begin
            div_valid_ff[k+1] <= div_valid_ff[k];
         end
         div_geo_ff[k+1]  <= div_geo_ff[k];
         div_len2_ff[k+1] <= div_len2_ff[k];
         div_rem_ff[k+1]  <= rem_in;
         div_q_ff[k+1]    <= {div_q_ff[k][QW-2:0], take};
      end
   end

   // ---------------------------------------------------------------
   // offset products |ab| * t
   // ---------------------------------------------------------------
   logic          om_valid_ff;
   geo_type       om_geo_ff;
   logic [OW-1:0] om_offx_ff, om_offy_ff;
   logic [DW-1:0] mag_x, mag_y;

   always_comb begin
      mag_x = div_geo_ff[F+1].abx[DW-1] ? DW'(-div_geo_ff[F+1].abx)
                                        : DW'(div_geo_ff[F+1].abx);
      mag_y = div_geo_ff[F+1].aby[DW-1] ? DW'(-div_geo_ff[F+1].aby)
                                        : DW'(div_geo_ff[F+1].aby);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         om_valid_ff <= 1'b0;
      end else begin
         om_valid_ff <= div_valid_ff[F+1];
      end
      om_geo_ff  <= div_geo_ff[F+1];
      om_offx_ff <= OW'(mag_x) * OW'(div_q_ff[F+1]);
      om_offy_ff <= OW'(mag_y) * OW'(div_q_ff[F+1]);
   end

   // ---------------------------------------------------------------
   // nearest point selection
   // ---------------------------------------------------------------
   localparam int NW = OW - F;   // truncated offset, W + 2 bits

   logic                pt_valid_ff;
   pnt_type             pt_ff;
   logic signed [W-1:0] pt_px_ff, pt_py_ff;
   logic [NW-1:0]       offx, offy;
   pnt_type             pt_in;

   always_comb begin
      offx       = om_offx_ff[OW-1:F];
      offy       = om_offy_ff[OW-1:F];
      pt_in.kind = om_geo_ff.kind;
      case (om_geo_ff.kind)
         csg_pkg::CLAMP_INTERIOR: begin
            pt_in.nx = om_geo_ff.abx[DW-1] ? W'(NW'(om_geo_ff.ax) - offx)
                                           : W'(NW'(om_geo_ff.ax) + offx);
            pt_in.ny = om_geo_ff.aby[DW-1] ? W'(NW'(om_geo_ff.ay) - offy)
                                           : W'(NW'(om_geo_ff.ay) + offy);
         end
         csg_pkg::CLAMP_END: begin
            pt_in.nx = om_geo_ff.bx;
            pt_in.ny = om_geo_ff.by;
         end
         default: begin
            pt_in.nx = om_geo_ff.ax;
            pt_in.ny = om_geo_ff.ay;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_valid_ff <= 1'b0;
      end else begin
         pt_valid_ff <= om_valid_ff;
      end
      pt_ff    <= pt_in;
      pt_px_ff <= om_geo_ff.px;
      pt_py_ff <= om_geo_ff.py;
   end

   // ---------------------------------------------------------------
   // distance vector, squares, squared distance
   // ---------------------------------------------------------------
   logic                 dv_valid_ff, sq_valid_ff;
   pnt_type              dv_pt_ff, sq_pt_ff;
   logic signed [DW-1:0] dv_dx_ff, dv_dy_ff;
   logic signed [PW-1:0] sq_xx_ff, sq_yy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff <= 1'b0;
         sq_valid_ff <= 1'b0;
      end else begin
         dv_valid_ff <= pt_valid_ff;
         sq_valid_ff <= dv_valid_ff;
      end
      dv_pt_ff <= pt_ff;
      dv_dx_ff <= DW'(pt_px_ff) - DW'(pt_ff.nx);
      dv_dy_ff <= DW'(pt_py_ff) - DW'(pt_ff.ny);
      sq_pt_ff <= dv_pt_ff;
      sq_xx_ff <= dv_dx_ff * dv_dx_ff;
      sq_yy_ff <= dv_dy_ff * dv_dy_ff;
   end

   // square root pipeline, entry 0 holds the radicand
   logic          sr_valid_ff [0:W+1];
   pnt_type       sr_pt_ff    [0:W+1];
   logic [PW-1:0] sr_rem_ff   [0:W+1];
   logic [W:0]    sr_root_ff  [0:W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_valid_ff[0] <= 1'b0;
      end else begin
         sr_valid_ff[0] <= sq_valid_ff;
      end
      sr_pt_ff[0]   <= sq_pt_ff;
      sr_rem_ff[0]  <= PW'($unsigned(sq_xx_ff)) + PW'($unsigned(sq_yy_ff));
      sr_root_ff[0] <= '0;
   end

   // ---------------------------------------------------------------
   // square root: stage j decides root bit W - j
   // ---------------------------------------------------------------
   for (genvar j = 0; j <= W; j++) begin : g_sqrt
      localparam int BIT = W - j;
      logic [PW:0] trial;
      logic        take;

      always_comb begin
         // (root + 2^bit)^2 - root^2
         trial = ((PW+1)'(sr_root_ff[j]) << (BIT + 1)) + ((PW+1)'(1) << (2 * BIT));
         take  = {1'b0, sr_rem_ff[j]} >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sr_valid_ff[j+1] <= 1'b0;
         end else begin
            sr_valid_ff[j+1] <= sr_valid_ff[j];
         end
         sr_pt_ff[j+1] <= sr_pt_ff[j];
         if (take) begin
            sr_rem_ff[j+1]  <= PW'({1'b0, sr_rem_ff[j]} - trial);
            sr_root_ff[j+1] <= sr_root_ff[j] | ((W+1)'(1) << BIT);
         end else begin
            sr_rem_ff[j+1]  <= sr_rem_ff[j];
            sr_root_ff[j+1] <= sr_root_ff[j];
         end
      end
   end

   // ---------------------------------------------------------------
   // result register with saturation
   // ---------------------------------------------------------------
   logic         rsp_valid_ff;
   pnt_type      rsp_pt_ff;
   logic [W-1:0] rsp_dist_ff;
   logic         rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sr_valid_ff[W+1];
      end
      rsp_pt_ff   <= sr_pt_ff[W+1];
      rsp_sat_ff  <= sr_root_ff[W+1][W];
      rsp_dist_ff <= sr_root_ff[W+1][W] ? '1 : sr_root_ff[W+1][W-1:0];
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_nearest_x          = rsp_pt_ff.nx;
   assign rsp_nearest_y          = rsp_pt_ff.ny;
   assign rsp_clamp_case         = rsp_pt_ff.kind;
   assign rsp_distance           = rsp_dist_ff;
   assign rsp_distance_saturated = rsp_sat_ff;

endmodule
